// ----- hdl/fourier_series_evaluator_top_assert.svh -----
// assertion macros for the fourier series evaluator
// each macro samples on i_clk and is disabled while i_rst_n is low
`ifndef FOURIER_SERIES_EVALUATOR_TOP_ASSERT_SVH
`define FOURIER_SERIES_EVALUATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define FSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fse assertion failed");

`define FSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fse assertion failed");

`else

`define FSE_ASSERT_IMP(lbl, ante, cons)

`define FSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/fse_pkg.sv -----
package fse_pkg;

    localparam int MAX_TERMS_DEF       = 64;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int COEF_BITS     = 24;
    localparam int X_BITS        = 32;
    localparam int SERIES_BITS   = 32;
    localparam int INDEX_BITS    = 6;
    localparam int REQ_BITS      = 2;
    localparam int PERIOD_BITS   = 32;
    localparam int HCOUNT_BITS   = 7;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam int PHASE_BITS    = 48;
    localparam int SINE_W        = 17;
    localparam int FRAC_BITS     = 16;
    localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);

    localparam int IN_DATA_BITS  = ((INDEX_BITS + 2 * COEF_BITS + X_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SERIES_BITS + 2 * COEF_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    localparam logic [REQ_BITS-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_EVAL  = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_NONE  = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERSE_PERIOD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HARMONIC_COUNT = 1'b1;

    localparam logic [PERIOD_BITS-1:0] INV_PERIOD_RST = 32'd65536;
    localparam logic [HCOUNT_BITS-1:0] HCOUNT_RST     = 7'd1;

    localparam logic [SERIES_BITS-1:0] SERIES_MAX = 32'h7FFF_FFFF;
    localparam logic [SERIES_BITS-1:0] SERIES_MIN = 32'h8000_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // one quarter-wave lookup: magnitude in q1.16 and the sign of the half wave
    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } t_sine_rd;

    // sin(pi/2 * idx / 2^bits) in q1.16, taylor series in q2.30, capped at one
    function automatic logic [SINE_W-1:0] sine_rom_entry(input int unsigned idx,
                                                         input int unsigned bits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        t    = (64'(idx) * HALF_PI_Q30) >> bits;
        t2   = (t * t) >> 30;
        term = t;
        sum  = t;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        e = (sum + 64'd8192) >> 14;
        if (e > 64'd65536) begin
            e = 64'd65536;
        end
        return SINE_W'(e);
    endfunction

endpackage

// ----- hdl/fse_sine_rom.sv -----
module fse_sine_rom #(
    parameter int SineTableBits = fse_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [SineTableBits+1:0] i_phase_c,
    input  logic [SineTableBits+1:0] i_phase_s,
    output fse_pkg::t_sine_rd        o_cos,
    output fse_pkg::t_sine_rd        o_sin
);
    import fse_pkg::*;

    localparam int IdxW   = SineTableBits + 1;
    localparam int RomLen = (1 << SineTableBits) + 1;
    localparam logic [IdxW-1:0] IdxTop = IdxW'(1) << SineTableBits;

    logic [SINE_W-1:0] rom [RomLen];
    logic [IdxW-1:0]   idx_c;
    logic [IdxW-1:0]   idx_s;
    t_sine_rd          r_cos;
    t_sine_rd          r_sin;

    for (genvar g = 0; g < RomLen; g++) begin : g_rom
        assign rom[g] = sine_rom_entry(g, SineTableBits);
    end

    // odd quadrants run the quarter wave backwards
    function automatic logic [IdxW-1:0] fold(input logic [SineTableBits+1:0] ph);
        logic [IdxW-1:0] idx;
        idx = {1'b0, ph[SineTableBits-1:0]};
        return ph[SineTableBits] ? (IdxTop - idx) : idx;
    endfunction

    assign idx_c = fold(i_phase_c);
    assign idx_s = fold(i_phase_s);

    always_ff @(posedge i_clk) begin
        r_cos.mag <= rom[idx_c];
        r_cos.neg <= i_phase_c[SineTableBits+1];
        r_sin.mag <= rom[idx_s];
        r_sin.neg <= i_phase_s[SineTableBits+1];
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ----- hdl/fourier_series_evaluator_top.sv -----
// states per item: write exec, done; read exec, rdata, done; evaluate exec, n issues,
// drain, round, clip, done, n = harmonic_count limited to MaxTerms (exec, done when n is 0)
// evaluation reads one coefficient pair per cycle from the store, behind a 4-stage mac pipe
// one item at a time; the next item can be accepted in the cycle after the result is registered
// reset (synchronous, active low) loads config defaults, clears store per-entry valid bits
`include "fourier_series_evaluator_top_assert.svh"

module fourier_series_evaluator_top #(
    parameter int MaxTerms      = fse_pkg::MAX_TERMS_DEF,
    parameter int SineTableBits = fse_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // coef_index, coef_a_in, coef_b_in, x_pos, zero pad
    input  logic [fse_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // req_type
    input  logic [fse_pkg::REQ_BITS-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // series_value, coef_a_out, coef_b_out
    output logic [fse_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // index_error, sum_saturated
    output logic [fse_pkg::OUT_USER_BITS-1:0]   m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [fse_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [fse_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import fse_pkg::*;

    localparam int AddrW = $clog2(MaxTerms);
    localparam int CntW  = $clog2(MaxTerms + 1);
    localparam int ProdW = COEF_BITS + SINE_W + 1;
    localparam int TermW = ProdW + 1;
    localparam int AccW  = TermW + $clog2(MaxTerms) + 1;
    localparam int RndW  = (AccW > 48) ? AccW + 1 : 49;
    localparam int QW    = RndW - FRAC_BITS;
    localparam int PtopW = SineTableBits + 2;
    localparam int MemW  = 2 * COEF_BITS;
    localparam int ALsb  = INDEX_BITS;
    localparam int BLsb  = ALsb + COEF_BITS;
    localparam int XLsb  = BLsb + COEF_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND,
        ST_CLIP,
        ST_DONE
    } t_state;

    t_state r_state;

    // config
    logic [PERIOD_BITS-1:0] r_inv_period;
    logic [HCOUNT_BITS-1:0] r_hcount;

    // captured item
    logic [REQ_BITS-1:0]          r_req;
    logic [INDEX_BITS-1:0]        r_index;
    logic [COEF_BITS-1:0]         r_a_in;
    logic [COEF_BITS-1:0]         r_b_in;
    logic signed [X_BITS-1:0]     r_x;
    logic                         r_bad;
    logic [CntW-1:0]              r_count;

    // coefficient store
    logic [MemW-1:0]      r_mem [MaxTerms];
    logic [MaxTerms-1:0]  r_valid;
    logic [MemW-1:0]      r_rd_data;
    logic                 r_rd_valid;
    logic [AddrW-1:0]     rd_addr;
    logic [AddrW-1:0]     wr_addr;
    logic                 mem_we;

    // evaluation loop
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS-1:0]          r_pk;
    logic [CntW-1:0]                r_k;
    logic signed [X_BITS+PERIOD_BITS:0] phase_prod;
    logic [PtopW-1:0]               pk_top;
    logic [PtopW-1:0]               pc_top;
    t_sine_rd                       rom_cos;
    t_sine_rd                       rom_sin;
    logic                           issue;
    logic                           r_p1_vld;
    logic                           r_p2_vld;
    logic                           r_p3_vld;
    logic                           r_p1_k0;
    logic signed [COEF_BITS-1:0]    coef_a;
    logic signed [COEF_BITS-1:0]    coef_b;
    logic signed [ProdW-1:0]        n_prod_c;
    logic signed [ProdW-1:0]        n_prod_s;
    logic signed [ProdW-1:0]        r_prod_c;
    logic signed [ProdW-1:0]        r_prod_s;
    logic                           r_neg_c;
    logic                           r_neg_s;
    logic signed [TermW-1:0]        n_term;
    logic signed [TermW-1:0]        r_term;
    logic signed [AccW-1:0]         r_acc;
    logic signed [RndW-1:0]         rnd_sum;
    logic signed [QW-1:0]           n_q;
    logic signed [QW-1:0]           r_q;
    logic                           sat_hi;
    logic                           sat_lo;

    // pending result and output register
    logic [SERIES_BITS-1:0] r_res_series;
    logic [COEF_BITS-1:0]   r_res_a;
    logic [COEF_BITS-1:0]   r_res_b;
    logic                   r_res_err;
    logic                   r_res_sat;
    logic                   r_m_valid;
    logic [SERIES_BITS-1:0] r_m_series;
    logic [COEF_BITS-1:0]   r_m_a;
    logic [COEF_BITS-1:0]   r_m_b;
    logic                   r_m_err;
    logic                   r_m_sat;

    // input fields
    logic [INDEX_BITS-1:0] in_index;
    logic [COEF_BITS-1:0]  in_a;
    logic [COEF_BITS-1:0]  in_b;
    logic [X_BITS-1:0]     in_x;
    logic                  in_accept;
    logic [CntW-1:0]       eff_count;
    logic                  in_bad;

    assign in_index  = s_axis_tdata[INDEX_BITS-1:0];
    assign in_a      = s_axis_tdata[ALsb +: COEF_BITS];
    assign in_b      = s_axis_tdata[BLsb +: COEF_BITS];
    assign in_x      = s_axis_tdata[XLsb +: X_BITS];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (int'(r_hcount) > MaxTerms) begin
            eff_count = CntW'(MaxTerms);
        end else begin
            eff_count = CntW'(r_hcount);
        end
        in_bad = int'(in_index) >= int'(eff_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_period <= INV_PERIOD_RST;
            r_hcount     <= HCOUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INVERSE_PERIOD: r_inv_period <= i_cfg_wdata;
                CFG_HARMONIC_COUNT: r_hcount     <= i_cfg_wdata[HCOUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // store: one write port, one read port, registered read
    assign issue   = (r_state == ST_ISSUE);
    assign wr_addr = AddrW'(r_index);
    assign rd_addr = issue ? r_k[AddrW-1:0] : AddrW'(r_index);
    assign mem_we  = (r_state == ST_EXEC) && (r_req == REQ_WRITE) && !r_bad;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {r_b_in, r_a_in};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[wr_addr] <= 1'b1;
        end
        r_rd_valid <= r_valid[rd_addr];
    end

    // phase in turns, 48 fractional bits
    assign phase_prod = r_x * $signed({1'b0, r_inv_period});

    // cosine is the sine a quarter turn later
    assign pk_top = r_pk[PHASE_BITS-1 -: PtopW];
    assign pc_top = pk_top + {2'b01, {SineTableBits{1'b0}}};

    fse_sine_rom #(
        .SineTableBits (SineTableBits)
    ) u_sine_rom (
        .i_clk     (i_clk),
        .i_phase_c (pc_top),
        .i_phase_s (pk_top),
        .o_cos     (rom_cos),
        .o_sin     (rom_sin)
    );

    always_comb begin
        coef_a = r_rd_valid ? $signed(r_rd_data[COEF_BITS-1:0]) : '0;
        coef_b = r_rd_valid ? $signed(r_rd_data[MemW-1:COEF_BITS]) : '0;
        if (r_p1_k0) begin
            // dc term: a0 / 2 in the q.32 sum
            n_prod_c = ProdW'(coef_a) <<< (FRAC_BITS - 1);
            n_prod_s = '0;
        end else begin
            n_prod_c = coef_a * $signed({1'b0, rom_cos.mag});
            n_prod_s = coef_b * $signed({1'b0, rom_sin.mag});
        end
    end

    assign n_term = (r_neg_c ? -TermW'(r_prod_c) : TermW'(r_prod_c))
                  + (r_neg_s ? -TermW'(r_prod_s) : TermW'(r_prod_s));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_k0  <= (r_k == '0);
        r_prod_c <= n_prod_c;
        r_prod_s <= n_prod_s;
        r_neg_c  <= !r_p1_k0 && rom_cos.neg;
        r_neg_s  <= !r_p1_k0 && rom_sin.neg;
        r_term   <= n_term;
        if (r_state == ST_EXEC) begin
            r_acc <= '0;
        end else if (r_p3_vld) begin
            r_acc <= r_acc + AccW'(r_term);
        end
    end

    // round half up to q16.16 (floor after adding one half), then clip
    always_comb begin
        rnd_sum = RndW'(r_acc) + RndW'(ROUND_HALF);
        n_q     = QW'(rnd_sum >>> FRAC_BITS);
        sat_hi  = r_q > $signed({{(QW - SERIES_BITS){1'b0}}, SERIES_MAX});
        sat_lo  = r_q < $signed({{(QW - SERIES_BITS){1'b1}}, SERIES_MIN});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // the done state sets or holds the output valid itself
            if (m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_req        <= s_axis_tuser;
                        r_index      <= in_index;
                        r_a_in       <= in_a;
                        r_b_in       <= in_b;
                        r_x          <= $signed(in_x);
                        r_bad        <= in_bad;
                        r_count      <= eff_count;
                        r_res_series <= '0;
                        r_res_a      <= '0;
                        r_res_b      <= '0;
                        r_res_err    <= 1'b0;
                        r_res_sat    <= 1'b0;
                        r_state      <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (r_req)
                        REQ_WRITE: begin
                            r_res_err <= r_bad;
                            r_state   <= ST_DONE;
                        end
                        REQ_READ: begin
                            r_state <= ST_RDATA;
                        end
                        REQ_EVAL: begin
                            if (r_count == '0) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_phase <= phase_prod[PHASE_BITS-1:0];
                                r_pk    <= '0;
                                r_k     <= '0;
                                r_state <= ST_ISSUE;
                            end
                        end
                        REQ_NONE: r_state <= ST_DONE;
                        default:  r_state <= ST_DONE;
                    endcase
                end
                ST_RDATA: begin
                    r_res_err <= r_bad;
                    if (!r_bad && r_rd_valid) begin
                        r_res_a <= r_rd_data[COEF_BITS-1:0];
                        r_res_b <= r_rd_data[MemW-1:COEF_BITS];
                    end
                    r_state <= ST_DONE;
                end
                ST_ISSUE: begin
                    r_pk <= r_pk + r_phase;
                    r_k  <= r_k + CntW'(1);
                    if (r_k == r_count - CntW'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_p1_vld && !r_p2_vld && !r_p3_vld) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_q     <= n_q;
                    r_state <= ST_CLIP;
                end
                ST_CLIP: begin
                    if (sat_hi) begin
                        r_res_series <= SERIES_MAX;
                    end else if (sat_lo) begin
                        r_res_series <= SERIES_MIN;
                    end else begin
                        r_res_series <= r_q[SERIES_BITS-1:0];
                    end
                    r_res_sat <= sat_hi || sat_lo;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    // hold here while the previous result is still waiting
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_series <= r_res_series;
                        r_m_a      <= r_res_a;
                        r_m_b      <= r_res_b;
                        r_m_err    <= r_res_err;
                        r_m_sat    <= r_res_sat;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_m_b, r_m_a, r_m_series});
    assign m_axis_tuser  = {r_m_sat, r_m_err};

    `FSE_ASSERT_IMP(a_issue_in_range, r_state == ST_ISSUE, r_k < r_count)
    `FSE_ASSERT_IMP(a_flags_exclusive, r_m_valid, !(r_m_err && r_m_sat))
    `FSE_ASSERT_NXT(a_bad_write_no_fill, (r_state == ST_EXEC) && (r_req == REQ_WRITE) && r_bad, $stable(r_valid))
    `FSE_ASSERT_IMP(a_series_excl_coef, r_m_valid && (r_m_series != '0), (r_m_a == '0) && (r_m_b == '0))

endmodule
